// ===== rtl/gbc_pkg.sv =====
`timescale 1ns / 1ps

package gbc_pkg;

    // Sample format
    localparam int RAW_W     = 16;                      // raw field width on the port
    localparam int RAW_BITS  = 16;                      // bits of the raw field in use
    localparam int FRAC_BITS = 8;
    localparam int MAX_SHIFT = 4;                       // 2000 dps range code
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;

    localparam int SCALED_W  = RAW_BITS + MAX_SHIFT;    // scaled sample, signed
    localparam int OFFSET_W  = SCALED_W + FRAC_BITS;    // offset with fraction bits
    localparam int WIDE_W    = OFFSET_W + 1;            // corrected rate before trim
    localparam int RATE_W    = 29;

    // Register widths
    localparam int RANGE_W   = 3;
    localparam int CNT_W     = 16;
    localparam int WIN_W     = 8;
    localparam int LIMIT_W   = 20;
    localparam int SUM_W     = SCALED_W + CNT_W + 1;

    // Offset divider
    localparam int DIVD_W    = SUM_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    // APB
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [RANGE_W-1:0] RANGE_RST  = RANGE_W'(0);
    localparam logic [CNT_W-1:0]   WLEN_RST   = CNT_W'(6000);
    localparam logic [WIN_W-1:0]   MAXWIN_RST = WIN_W'(2);
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(2253);

    typedef enum logic [1:0] {
        REG_RANGE,
        REG_WLEN,
        REG_MAXWIN,
        REG_LIMIT
    } t_reg_idx;

    typedef struct packed {
        logic [RANGE_W-1:0] range_code;
        logic [CNT_W-1:0]   window_length;
        logic [WIN_W-1:0]   max_windows;
        logic [LIMIT_W-1:0] spread_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              load_in;
        logic              scale;
        logic              update;
        logic              check;
        logic              div_start;
        logic              write_offset;
        logic              finish;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic win_end;
        logic final_win;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/gbc_if.sv =====
`timescale 1ns / 1ps

interface gbc_in_if;
    import gbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;

    modport source (output valid, output op, output raw_x, output raw_y, output raw_z,
                    input ready);
    modport sink   (input valid, input op, input raw_x, input raw_y, input raw_z,
                    output ready);
endinterface

interface gbc_out_if;
    import gbc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     calibrating;
    logic                     calib_done;
    logic                     calib_passed;

    modport source (output valid, output rate_x, output rate_y, output rate_z,
                    output calibrating, output calib_done, output calib_passed,
                    input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                    input calibrating, input calib_done, input calib_passed,
                    output ready);
endinterface

// ===== rtl/gbc_regs.sv =====
`timescale 1ns / 1ps

module gbc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [gbc_pkg::APB_AW-1:0]   i_paddr,
    input  logic [gbc_pkg::APB_DW-1:0]   i_pwdata,
    output logic [gbc_pkg::APB_DW-1:0]   o_prdata,
    output logic                         o_pready,
    output gbc_pkg::t_cfg                o_cfg
);
    import gbc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_code    <= RANGE_RST;
            r_cfg.window_length <= WLEN_RST;
            r_cfg.max_windows   <= MAXWIN_RST;
            r_cfg.spread_limit  <= LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RANGE:  r_cfg.range_code    <= i_pwdata[RANGE_W-1:0];
                REG_WLEN:   r_cfg.window_length <= i_pwdata[CNT_W-1:0];
                REG_MAXWIN: r_cfg.max_windows   <= i_pwdata[WIN_W-1:0];
                REG_LIMIT:  r_cfg.spread_limit  <= i_pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RANGE:  o_prdata = APB_DW'(r_cfg.range_code);
            REG_WLEN:   o_prdata = APB_DW'(r_cfg.window_length);
            REG_MAXWIN: o_prdata = APB_DW'(r_cfg.max_windows);
            REG_LIMIT:  o_prdata = APB_DW'(r_cfg.spread_limit);
        endcase
    end

endmodule

// ===== rtl/gbc_div.sv =====
`timescale 1ns / 1ps

module gbc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gbc_pkg::SUM_W-1:0]   i_dividend,
    input  logic        [gbc_pkg::CNT_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic signed [gbc_pkg::OFFSET_W-1:0] o_quotient
);
    import gbc_pkg::*;

    logic [DIVD_W-1:0]    r_q;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_d;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [SUM_W-1:0]     w_mag;
    logic [CNT_W:0]       w_trial;
    logic                 w_ge;
    logic [DIVD_W-1:0]    w_qs;

    // magnitude of the sum; it is scaled up by the fraction bits on start
    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_q[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_qs    = r_neg ? DIVD_W'(-r_q) : r_q;

    assign o_done     = r_done;
    assign o_quotient = w_qs[OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DIVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= DIVD_W'(w_mag) << FRAC_BITS;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? CNT_W'(w_trial - {1'b0, r_d}) : w_trial[CNT_W-1:0];
        end
    end

endmodule

// ===== rtl/gbc_ctrl.sv =====
`timescale 1ns / 1ps

module gbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gbc_pkg::t_status  i_status,
    output gbc_pkg::t_cmd     o_cmd
);
    import gbc_pkg::*;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.axis = r_axis;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.win_end ? S_CHECK : S_EMIT;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_axis      = '0;
                n_state     = i_status.final_win ? S_DIV_GO : S_EMIT;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.write_offset = 1'b1;
                    if (r_axis == AXIS_W'(AXES - 1)) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_EMIT;
                    end else begin
                        n_axis  = r_axis + AXIS_W'(1);
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gbc_dp.sv =====
`timescale 1ns / 1ps

module gbc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbc_pkg::t_cmd                     i_cmd,
    output gbc_pkg::t_status                  o_status,
    input  gbc_pkg::t_cfg                     i_cfg,
    input  logic                              i_op,
    input  logic signed [gbc_pkg::RAW_W-1:0]  i_raw_x,
    input  logic signed [gbc_pkg::RAW_W-1:0]  i_raw_y,
    input  logic signed [gbc_pkg::RAW_W-1:0]  i_raw_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [gbc_pkg::RATE_W-1:0] o_rate_x,
    output logic signed [gbc_pkg::RATE_W-1:0] o_rate_y,
    output logic signed [gbc_pkg::RATE_W-1:0] o_rate_z,
    output logic                              o_calibrating,
    output logic                              o_calib_done,
    output logic                              o_calib_passed
);
    import gbc_pkg::*;

    // request and per-item results
    logic                       r_op;
    logic        [RAW_W-1:0]    r_raw    [AXES];
    logic signed [SCALED_W-1:0] r_scaled [AXES];
    logic signed [RATE_W-1:0]   r_rate   [AXES];

    // calibration state
    logic signed [OFFSET_W-1:0] r_offset [AXES];
    logic signed [SUM_W-1:0]    r_sum    [AXES];
    logic signed [SCALED_W-1:0] r_max    [AXES];
    logic signed [SCALED_W-1:0] r_min    [AXES];
    logic [CNT_W-1:0]           r_sample_count;
    logic [CNT_W-1:0]           r_div_count;
    logic [WIN_W-1:0]           r_window_count;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_passed;
    logic                       r_ok;

    // output register
    logic                       r_out_valid;
    logic signed [RATE_W-1:0]   r_out_rate [AXES];
    logic                       r_out_calibrating;
    logic                       r_out_done;
    logic                       r_out_passed;

    logic [RANGE_W-1:0]         w_rng;
    logic [CNT_W-1:0]           w_wl;
    logic [WIN_W-1:0]           w_mw;
    logic signed [SCALED_W-1:0] w_ext    [AXES];
    logic signed [SCALED_W-1:0] w_scaled [AXES];
    logic signed [WIDE_W-1:0]   w_wide   [AXES];
    logic [SCALED_W:0]          w_spread [AXES];
    logic [CNT_W:0]             w_count;
    logic [WIN_W:0]             w_wc;
    logic                       w_win_end;
    logic                       w_ok;
    logic                       w_final;
    logic                       w_div_done;
    logic signed [OFFSET_W-1:0] w_quot;

    assign w_rng = (i_cfg.range_code > RANGE_W'(MAX_SHIFT)) ? RANGE_W'(MAX_SHIFT)
                                                             : i_cfg.range_code;
    assign w_wl  = (i_cfg.window_length == '0) ? CNT_W'(1) : i_cfg.window_length;
    assign w_mw  = (i_cfg.max_windows == '0) ? WIN_W'(1) : i_cfg.max_windows;

    always_comb begin
        w_ok = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            w_ext[a]    = {{(SCALED_W-RAW_BITS){r_raw[a][RAW_BITS-1]}},
                           r_raw[a][RAW_BITS-1:0]};
            w_scaled[a] = w_ext[a] <<< w_rng;
            w_wide[a]   = (WIDE_W'(w_scaled[a]) <<< FRAC_BITS) - WIDE_W'(r_offset[a]);
            w_spread[a] = (SCALED_W+1)'(r_max[a]) - (SCALED_W+1)'(r_min[a]);
            if (32'(w_spread[a]) >= 32'(i_cfg.spread_limit)) begin
                w_ok = 1'b0;
            end
        end
    end

    assign w_count   = {1'b0, r_sample_count} + (CNT_W+1)'(1);
    assign w_win_end = r_busy && !r_op && (w_count >= {1'b0, w_wl});
    assign w_wc      = {1'b0, r_window_count} + (WIN_W+1)'(1);
    assign w_final   = w_ok || (w_wc >= {1'b0, w_mw});

    gbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum[i_cmd.axis]),
        .i_divisor  (r_div_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_status.win_end   = w_win_end;
    assign o_status.final_win = w_final;
    assign o_status.div_done  = w_div_done;
    assign o_status.out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_op;
            r_raw[0] <= i_raw_x;
            r_raw[1] <= i_raw_y;
            r_raw[2] <= i_raw_z;
        end
        if (i_cmd.scale) begin
            for (int a = 0; a < AXES; a++) begin
                r_scaled[a] <= w_scaled[a];
                r_rate[a]   <= RATE_W'(w_wide[a]);
            end
        end
        if (i_cmd.check) begin
            r_ok <= w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_offset[a] <= '0;
                r_sum[a]    <= '0;
                r_max[a]    <= '0;
                r_min[a]    <= '0;
            end
            r_sample_count <= '0;
            r_div_count    <= '0;
            r_window_count <= '0;
            r_busy         <= 1'b0;
            r_done         <= 1'b0;
            r_passed       <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_done   <= 1'b0;
                r_passed <= 1'b0;
                if (r_op) begin
                    // start request: restart from scratch
                    r_busy         <= 1'b1;
                    r_window_count <= '0;
                    r_sample_count <= '0;
                    for (int a = 0; a < AXES; a++) begin
                        r_sum[a] <= '0;
                        r_max[a] <= '0;
                        r_min[a] <= '0;
                    end
                end else if (r_busy) begin
                    for (int a = 0; a < AXES; a++) begin
                        if (r_sample_count == '0) begin
                            r_max[a] <= r_scaled[a];
                            r_min[a] <= r_scaled[a];
                        end else begin
                            if (r_scaled[a] > r_max[a]) r_max[a] <= r_scaled[a];
                            if (r_scaled[a] < r_min[a]) r_min[a] <= r_scaled[a];
                        end
                        r_sum[a] <= r_sum[a] + SUM_W'(r_scaled[a]);
                    end
                    if (w_win_end) begin
                        r_div_count <= w_count[CNT_W-1:0];
                    end else begin
                        r_sample_count <= w_count[CNT_W-1:0];
                    end
                end
            end
            // window over but more windows to go: start the next one
            if (i_cmd.check && !w_final) begin
                r_window_count <= w_wc[WIN_W-1:0];
                r_sample_count <= '0;
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a] <= '0;
                    r_max[a] <= '0;
                    r_min[a] <= '0;
                end
            end
            if (i_cmd.write_offset) begin
                r_offset[i_cmd.axis] <= w_quot;
            end
            if (i_cmd.finish) begin
                r_busy         <= 1'b0;
                r_done         <= 1'b1;
                r_passed       <= r_ok;
                r_window_count <= '0;
                r_sample_count <= '0;
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a] <= '0;
                    r_max[a] <= '0;
                    r_min[a] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_rate[a] <= r_op ? '0 : r_rate[a];
            end
            r_out_calibrating <= r_busy;
            r_out_done        <= r_done;
            r_out_passed      <= r_passed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rate_x       = r_out_rate[0];
    assign o_rate_y       = r_out_rate[1];
    assign o_rate_z       = r_out_rate[2];
    assign o_calibrating  = r_out_calibrating;
    assign o_calib_done   = r_out_done;
    assign o_calib_passed = r_out_passed;

endmodule

// ===== rtl/gyro_bias_calibrator.sv =====
`timescale 1ns / 1ps

// Gyro bias calibrator. Every request gives one result: a gyro sample is
// shifted left by the range code (capped at 4), given 8 fraction bits and
// has the stored per-axis offset taken off; a start request clears the
// statistics and begins a calibration, which collects windows of
// window_length samples and, once a window has every axis spread below
// spread_limit or max_windows windows have ended, sets each offset to the
// window mean. One request is handled at a time: after acceptance it passes
// through S_SCALE and S_UPDATE, then S_CHECK when it closes a window, then
// S_DIV_GO and S_DIV_WAIT for each axis when it ends the calibration, since
// the three offsets go one after another through a shared restoring divider
// that produces one quotient bit (45 in all) per cycle, and in S_EMIT the
// result register is loaded once the output is free. The result register
// frees the input side, so the next request is taken while a result waits.
module gyro_bias_calibrator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gbc_in_if.sink                      i_sample,
    gbc_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbc_pkg::APB_AW-1:0]  paddr,
    input  logic [gbc_pkg::APB_DW-1:0]  pwdata,
    output logic [gbc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import gbc_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    gbc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    gbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gbc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg          (w_cfg),
        .i_op           (i_sample.op),
        .i_raw_x        (i_sample.raw_x),
        .i_raw_y        (i_sample.raw_y),
        .i_raw_z        (i_sample.raw_z),
        .o_valid        (o_result.valid),
        .i_ready        (o_result.ready),
        .o_rate_x       (o_result.rate_x),
        .o_rate_y       (o_result.rate_y),
        .o_rate_z       (o_result.rate_z),
        .o_calibrating  (o_result.calibrating),
        .o_calib_done   (o_result.calib_done),
        .o_calib_passed (o_result.calib_passed)
    );

    // one request in flight at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && i_sample.ready |=> !i_sample.ready)
        else $error("request accepted while another is in flight");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.calib_done |-> !o_result.calibrating)
        else $error("calibration reported done while still running");

    a_pass_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.calib_passed |-> o_result.calib_done)
        else $error("pass flag without end of calibration");

endmodule
